### hw/rtl/ldcp_pkg.sv
// Shared types and constants for the letter-decimal command parser.
package ldcp_pkg;

   localparam int unsigned MAX_FRAME_LEN_DEF = 32;
   localparam int unsigned VALUE_BITS_DEF    = 32;

   localparam logic [7:0] END_BYTE_RESET = 8'd10;
   localparam logic [7:0] CHAR_UPPER_A   = 8'd65;
   localparam logic [7:0] CHAR_UPPER_Z   = 8'd90;
   localparam logic [7:0] CHAR_DIGIT_0   = 8'd48;
   localparam logic [7:0] CHAR_DIGIT_9   = 8'd57;

   localparam int unsigned OUT_VALUE_BITS = 32;

   typedef enum logic [1:0] {
      ST_VALID     = 2'd0,
      ST_MALFORMED = 2'd1,
      ST_OVERFLOW  = 2'd2
   } ldcp_status_type;

   typedef struct packed {
      logic                        emit;
      ldcp_status_type             status;
      logic [7:0]                  letter;
      logic [OUT_VALUE_BITS-1:0]   value;
   } ldcp_result_type;

endpackage

### hw/rtl/ldcp_frame.sv
// Frame state and per-byte decode for the letter-decimal command parser.
module ldcp_frame import ldcp_pkg::*; #(
   parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
   parameter int unsigned VALUE_BITS    = VALUE_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      rx_byte,
   input  logic [7:0]      end_byte,
   output ldcp_result_type result
);

   localparam int unsigned LEN_BITS = $clog2(MAX_FRAME_LEN + 1);
   localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_FRAME_LEN);
   localparam logic [LEN_BITS-1:0] LEN_TWO = LEN_BITS'(2);

   logic [LEN_BITS-1:0]   len_ff, len_in;
   logic [7:0]            letter_ff, letter_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  still_valid_ff, still_valid_in;
   logic                  discard_ff, discard_in;

   logic                  is_end;
   logic                  is_letter;
   logic                  is_digit;
   logic [VALUE_BITS-1:0] digit;
   logic [VALUE_BITS-1:0] acc_next;
   logic [VALUE_BITS+OUT_VALUE_BITS-1:0] acc_wide;

   assign is_end    = (rx_byte == end_byte);
   assign is_letter = (rx_byte >= CHAR_UPPER_A) && (rx_byte <= CHAR_UPPER_Z);
   assign is_digit  = (rx_byte >= CHAR_DIGIT_0) && (rx_byte <= CHAR_DIGIT_9);
   assign digit     = VALUE_BITS'(rx_byte[3:0]);
   // Times ten as two shifted copies, wrapping at the accumulator width.
   assign acc_next  = (acc_ff << 3) + (acc_ff << 1) + digit;
   assign acc_wide  = {{OUT_VALUE_BITS{1'b0}}, acc_ff};

   always_comb begin
      len_in         = len_ff;
      letter_in      = letter_ff;
      acc_in         = acc_ff;
      still_valid_in = still_valid_ff;
      discard_in     = discard_ff;
      result         = '0;
      result.status  = ST_VALID;

      if (discard_ff) begin
         if (is_end) begin
            discard_in     = 1'b0;
            len_in         = '0;
            letter_in      = '0;
            acc_in         = '0;
            still_valid_in = 1'b1;
         end
      end else if (is_end) begin
         result.emit = 1'b1;
         if (still_valid_ff && (len_ff >= LEN_TWO)) begin
            result.status = ST_VALID;
            result.letter = letter_ff;
            result.value  = acc_wide[OUT_VALUE_BITS-1:0];
         end else begin
            result.status = ST_MALFORMED;
         end
         len_in         = '0;
         letter_in      = '0;
         acc_in         = '0;
         still_valid_in = 1'b1;
      end else if (len_ff >= LEN_MAX) begin
         result.emit    = 1'b1;
         result.status  = ST_OVERFLOW;
         discard_in     = 1'b1;
         len_in         = '0;
         letter_in      = '0;
         acc_in         = '0;
         still_valid_in = 1'b1;
      end else begin
         if (len_ff == '0) begin
            if (is_letter) begin
               letter_in = rx_byte;
            end else begin
               still_valid_in = 1'b0;
            end
         end else if (is_digit) begin
            acc_in = acc_next;
         end else begin
            still_valid_in = 1'b0;
         end
         len_in = len_ff + LEN_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff         <= '0;
         letter_ff      <= '0;
         acc_ff         <= '0;
         still_valid_ff <= 1'b1;
         discard_ff     <= 1'b0;
      end else if (step) begin
         len_ff         <= len_in;
         letter_ff      <= letter_in;
         acc_ff         <= acc_in;
         still_valid_ff <= still_valid_in;
         discard_ff     <= discard_in;
      end
   end

endmodule

### hw/rtl/letter_decimal_command_parser_core.sv
// Top level of the letter-decimal command parser: input register, decode, result register.
// A result is offered from the result register after its byte passes the input register.
// One byte per cycle unless stalled; the input and result registers decouple the sides.
// A byte that makes a result waits in the input register only while the result register
// is full and not being taken.
// Reset (synchronous, active high) empties both registers, clears the frame state and sets
// the end byte to line feed.
module letter_decimal_command_parser_core import ldcp_pkg::*; #(
   parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
   parameter int unsigned VALUE_BITS    = VALUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] command_letter, [39:8] command_value
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   logic [7:0]      end_byte_ff;
   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   ldcp_status_type rsp_status_ff;
   logic [39:0]     rsp_data_ff;
   logic            in_fire;
   logic            step;
   ldcp_result_type result;

   ldcp_frame #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN),
      .VALUE_BITS    (VALUE_BITS)
   ) u_frame (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .rx_byte  (in_byte_ff),
      .end_byte (end_byte_ff),
      .result   (result)
   );

   // The held item moves on unless it makes a result that has nowhere to go.
   assign step       = in_valid_ff && (!result.emit || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign in_fire    = req_tvalid && req_tready;
   assign in_valid_in = in_fire || (in_valid_ff && !step);

   always_comb begin
      if (step && result.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         end_byte_ff  <= END_BYTE_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            end_byte_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         in_byte_ff <= req_tdata;
      end
      if (step && result.emit) begin
         rsp_status_ff <= result.status;
         rsp_data_ff   <= {result.value, result.letter};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_VALID) |-> rsp_tdata == '0)
      else $error("non-valid status carries a nonzero letter or value");

   a_valid_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_VALID) |->
         (rsp_tdata[7:0] >= CHAR_UPPER_A) && (rsp_tdata[7:0] <= CHAR_UPPER_Z))
      else $error("valid command without an uppercase letter");

   a_held_stays: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_byte_ff))
      else $error("stalled input item lost or changed");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      step && result.emit |=> rsp_valid_ff)
      else $error("result produced but not held for the output");

endmodule
